FILE: hw/rtl/fcvm_pkg.sv
// ----------------------------------------------------------------------------
// fcvm_pkg
// Shared types, constants and lookup functions of the false-color value mapper.
// ----------------------------------------------------------------------------
package fcvm_pkg;

  // Default sample width (signed fixed point)
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Normalized fraction: Q0.16, 1.0 = 65536 needs 17 bits
  localparam int V_BITS   = 17;
  localparam int QUO_BITS = 16;
  localparam logic [V_BITS-1:0] V_ONE  = 17'd65536;
  localparam logic [V_BITS-1:0] V_ZERO = 17'd0;

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // CORDIC datapath
  localparam int ANG_W         = 20;
  localparam int CORDIC_STEPS  = 16;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int LANES         = 3;
  localparam int COEF_W        = 17;
  localparam int PROD_W        = COEF_W + ANG_W;
  localparam int SUM_W         = 40;
  localparam int SCALE_W       = SUM_W + 8;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 20'sd39797;

  typedef enum logic {CMD_SCAN = 1'b0, CMD_MAP = 1'b1} cmd_t;
  typedef enum logic {MAP_POLY = 1'b0, MAP_COOLWARM = 1'b1} map_t;

  // Classification of a map transaction made by the front
  typedef enum logic [1:0] {
    KIND_WHITE = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_ONE   = 2'd2,
    KIND_DIV   = 2'd3
  } kind_t;

  // atan(2^-i) in Q16 radians
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      4'd0:  r = 20'sd51472;
      4'd1:  r = 20'sd30386;
      4'd2:  r = 20'sd16055;
      4'd3:  r = 20'sd8150;
      4'd4:  r = 20'sd4091;
      4'd5:  r = 20'sd2047;
      4'd6:  r = 20'sd1024;
      4'd7:  r = 20'sd512;
      4'd8:  r = 20'sd256;
      4'd9:  r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  // Coolwarm angle factor per channel (Q16)
  function automatic logic [18:0] cw_angle(input int lane);
    logic [18:0] r;
    unique case (lane)
      0:       r = 19'd248250;
      1:       r = 19'd256508;
      default: r = 19'd263717;
    endcase
    return r;
  endfunction

  // Coolwarm constant term per channel (Q16)
  function automatic logic signed [COEF_W-1:0] cw_c0(input int lane);
    logic signed [COEF_W-1:0] r;
    unique case (lane)
      0:       r = 17'sd37775;
      1:       r = 17'sd26142;
      default: r = 17'sd38876;
    endcase
    return r;
  endfunction

  // Coolwarm cosine coefficient per channel (Q16)
  function automatic logic signed [COEF_W-1:0] cw_c1(input int lane);
    logic signed [COEF_W-1:0] r;
    unique case (lane)
      0:       r = -17'sd21706;
      1:       r = -17'sd7366;
      default: r = 17'sd10610;
    endcase
    return r;
  endfunction

  // Coolwarm sine coefficient per channel (Q16)
  function automatic logic signed [COEF_W-1:0] cw_c2(input int lane);
    logic signed [COEF_W-1:0] r;
    unique case (lane)
      0:       r = 17'sd13382;
      1:       r = 17'sd28783;
      default: r = 17'sd24556;
    endcase
    return r;
  endfunction

  // Saturate a signed value to 0..255
  function automatic logic [7:0] sat8(input logic signed [15:0] a);
    logic [7:0] r;
    if (a < 16'sd0) begin
      r = 8'd0;
    end else if (a > 16'sd255) begin
      r = 8'd255;
    end else begin
      r = a[7:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fcvm_ifs.sv
// ----------------------------------------------------------------------------
// fcvm interfaces
// Valid/ready channels of the mapper: sample input, color output, config.
// ----------------------------------------------------------------------------

// Sample channel
interface fcvm_in_if #(parameter int SAMPLE_WIDTH = fcvm_pkg::SAMPLE_WIDTH_DEF);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           first;

  modport source (output valid, command, sample, first, input ready);
  modport sink   (input valid, command, sample, first, output ready);
endinterface

// Color channel
interface fcvm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// Configuration write channel
interface fcvm_cfg_if;
  logic valid;
  logic ready;
  logic map_select;

  modport source (output valid, map_select, input ready);
  modport sink   (input valid, map_select, output ready);
endinterface

FILE: hw/rtl/false_color_value_mapper_top.sv
// ----------------------------------------------------------------------------
// false_color_value_mapper_top
// Scalar-to-RGB false-color mapper with polynomial and coolwarm color maps.
// ----------------------------------------------------------------------------
// A scan transaction updates the running minimum/maximum. A map transaction
// is classified on entry and queued (two deep); the color engine then takes
// one queued item at a time. Mapping a sample strictly inside the range
// starts with restoring division (one quotient bit per cycle); the coolwarm
// map then runs 16 CORDIC rotation steps in three parallel lanes. Negative
// samples and samples on or outside the range skip the divider. The color
// output is registered, so the engine starts the next item while a color
// waits to be taken.
// ----------------------------------------------------------------------------
module false_color_value_mapper_top #(
  parameter int SAMPLE_WIDTH = fcvm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fcvm_in_if.sink    item,
  fcvm_out_if.source color,
  fcvm_cfg_if.sink   cfg
);
  import fcvm_pkg::*;

  localparam int ENTRY_W = 2 + 2 * SAMPLE_WIDTH;

  logic                    map_select;
  logic                    push;
  kind_t                   kind;
  logic [SAMPLE_WIDTH-1:0] num;
  logic [SAMPLE_WIDTH-1:0] den;
  logic                    q_full;
  logic                    q_empty;
  logic                    pop;
  logic [ENTRY_W-1:0]      q_rdata;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_select <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      map_select <= cfg.map_select;
    end
  end

  fcvm_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .kind   (kind),
    .num    (num),
    .den    (den)
  );

  fcvm_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({kind, num, den}),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  fcvm_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .map_sel (map_t'(map_select)),
    .q_empty (q_empty),
    .q_kind  (kind_t'(q_rdata[ENTRY_W-1 -: 2])),
    .q_num   (q_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .q_den   (q_rdata[SAMPLE_WIDTH-1:0]),
    .pop     (pop),
    .color   (color)
  );

  // Checks
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("color engine took an item from an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("map transaction queued while queue full");

  a_white_negative: assert property (@(posedge clk) disable iff (rst)
    (push && (kind == KIND_WHITE)) |-> item.sample[SAMPLE_WIDTH-1])
    else $error("non-negative sample classified as white");

  a_range_kind: assert property (@(posedge clk) disable iff (rst)
    (push && (kind == KIND_DIV)) |-> (num < den))
    else $error("division queued with numerator not below range");

endmodule

FILE: hw/rtl/fcvm_front.sv
// ----------------------------------------------------------------------------
// fcvm_front
// Accepts samples, tracks the running range and classifies map transactions.
// ----------------------------------------------------------------------------
module fcvm_front #(
  parameter int SAMPLE_WIDTH = fcvm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  fcvm_in_if.sink                 item,
  input  logic                    q_full,
  output logic                    push,
  output fcvm_pkg::kind_t         kind,
  output logic [SAMPLE_WIDTH-1:0] num,
  output logic [SAMPLE_WIDTH-1:0] den
);
  import fcvm_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] range_low;
  logic signed [SAMPLE_WIDTH-1:0] range_high;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH:0]   diff_num;
  logic signed [SAMPLE_WIDTH:0]   diff_den;
  logic                           accept;

  assign x          = item.sample;
  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;
  assign push       = accept && (item.command == CMD_MAP);

  // Range tracking on scan transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= MOST_POS;
      range_high <= MOST_NEG;
    end else if (accept && (item.command == CMD_SCAN)) begin
      if (item.first) begin
        range_low  <= x;
        range_high <= x;
      end else begin
        if (x < range_low)  range_low  <= x;
        if (x > range_high) range_high <= x;
      end
    end
  end

  // Offsets from the range floor, one bit wider to hold any difference
  assign diff_num = $signed({x[SAMPLE_WIDTH-1], x}) -
                    $signed({range_low[SAMPLE_WIDTH-1], range_low});
  assign diff_den = $signed({range_high[SAMPLE_WIDTH-1], range_high}) -
                    $signed({range_low[SAMPLE_WIDTH-1], range_low});

  // Only strictly inside the range needs a division
  always_comb begin
    priority if (x[SAMPLE_WIDTH-1]) begin
      kind = KIND_WHITE;
    end else if (range_high <= range_low) begin
      kind = KIND_ZERO;
    end else if (diff_num <= $signed({(SAMPLE_WIDTH+1){1'b0}})) begin
      kind = KIND_ZERO;
    end else if (diff_num >= diff_den) begin
      kind = KIND_ONE;
    end else begin
      kind = KIND_DIV;
    end
  end

  assign num = diff_num[SAMPLE_WIDTH-1:0];
  assign den = diff_den[SAMPLE_WIDTH-1:0];

endmodule

FILE: hw/rtl/fcvm_queue.sv
// ----------------------------------------------------------------------------
// fcvm_queue
// Small register FIFO that decouples classification from color computation.
// ----------------------------------------------------------------------------
module fcvm_queue #(
  parameter int WIDTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import fcvm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/fcvm_back.sv
// ----------------------------------------------------------------------------
// fcvm_back
// Color engine: restoring divider, polynomial map, three-lane CORDIC coolwarm.
// ----------------------------------------------------------------------------
module fcvm_back #(
  parameter int SAMPLE_WIDTH = fcvm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fcvm_pkg::map_t          map_sel,
  input  logic                    q_empty,
  input  fcvm_pkg::kind_t         q_kind,
  input  logic [SAMPLE_WIDTH-1:0] q_num,
  input  logic [SAMPLE_WIDTH-1:0] q_den,
  output logic                    pop,
  fcvm_out_if.source              color
);
  import fcvm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SQ, ST_POLY, ST_ANGLE, ST_REDUCE,
    ST_ROT, ST_PROD, ST_SUM, ST_SCALE, ST_OUT
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t                     state;
  logic [STEP_W-1:0]          cnt;
  logic [SAMPLE_WIDTH-1:0]    rem;
  logic [SAMPLE_WIDTH-1:0]    den_r;
  logic [QUO_BITS-1:0]        quo;
  logic [V_BITS-1:0]          v;
  logic [V_BITS:0]            v2;
  logic signed [ANG_W-1:0]    cx   [LANES];
  logic signed [ANG_W-1:0]    cy   [LANES];
  logic signed [ANG_W-1:0]    cz   [LANES];
  logic                       neg  [LANES];
  logic signed [PROD_W-1:0]   p1   [LANES];
  logic signed [PROD_W-1:0]   p2   [LANES];
  logic signed [SUM_W-1:0]    sum  [LANES];
  logic [7:0]                 res  [LANES];

  // Combinational next values
  logic [SAMPLE_WIDTH:0]      rem_sh;
  logic                       rem_ge;
  logic [SAMPLE_WIDTH-1:0]    rem_next;
  logic [QUO_BITS-1:0]        quo_next;
  logic [2*V_BITS-1:0]        v_sq;
  logic [7:0]                 poly_ch   [LANES];
  logic signed [ANG_W-1:0]    theta     [LANES];
  logic signed [ANG_W-1:0]    x_next    [LANES];
  logic signed [ANG_W-1:0]    y_next    [LANES];
  logic signed [ANG_W-1:0]    z_next    [LANES];
  logic signed [PROD_W-1:0]   p1_next   [LANES];
  logic signed [PROD_W-1:0]   p2_next   [LANES];
  logic signed [SUM_W-1:0]    sum_next  [LANES];
  logic [7:0]                 cw_ch     [LANES];
  logic                       out_free;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !color.valid || color.ready;

  // One restoring division step
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = (rem_sh >= {1'b0, den_r});
  assign rem_next = rem_ge ? SAMPLE_WIDTH'(rem_sh - {1'b0, den_r}) : rem_sh[SAMPLE_WIDTH-1:0];
  assign quo_next = {quo[QUO_BITS-2:0], rem_ge};

  // Polynomial map channels from v and v^2
  assign v_sq = v * v;
  always_comb begin
    logic signed [19:0] t    [LANES];
    logic signed [27:0] sc;
    t[0] = $signed({2'b00, v, 1'b0}) - $signed({1'b0, v2});
    t[1] = ($signed({3'b000, v}) - $signed({1'b0, v2})) <<< 2;
    t[2] = $signed(20'sd65536) - $signed({1'b0, v2});
    for (int l = 0; l < LANES; l++) begin
      sc = $signed({t[l], 8'b0}) - $signed({{8{t[l][19]}}, t[l]});
      poly_ch[l] = sat8($signed({{4{sc[27]}}, sc[27:16]}));
    end
  end

  // Coolwarm lanes: angle, rotation, products, sum, scaling
  always_comb begin
    logic [18+V_BITS:0]         ang;
    logic signed [ANG_W-1:0]    xs;
    logic signed [ANG_W-1:0]    ys;
    logic signed [ANG_W-1:0]    cs;
    logic signed [ANG_W-1:0]    sn;
    logic signed [COEF_W-1:0]   c0;
    logic signed [SCALE_W-1:0]  sc;
    for (int l = 0; l < LANES; l++) begin
      ang      = cw_angle(l) * v;
      theta[l] = $signed(ang[18+V_BITS:V_BITS-1]);
      xs = cx[l] >>> cnt;
      ys = cy[l] >>> cnt;
      if (cz[l] >= 0) begin
        x_next[l] = cx[l] - ys;
        y_next[l] = cy[l] + xs;
        z_next[l] = cz[l] - atan_q16(cnt);
      end else begin
        x_next[l] = cx[l] + ys;
        y_next[l] = cy[l] - xs;
        z_next[l] = cz[l] + atan_q16(cnt);
      end
      cs = neg[l] ? -cx[l] : cx[l];
      sn = neg[l] ? -cy[l] : cy[l];
      p1_next[l]  = cw_c1(l) * cs;
      p2_next[l]  = cw_c2(l) * sn;
      c0          = cw_c0(l);
      sum_next[l] = $signed({{(SUM_W-COEF_W-16){c0[COEF_W-1]}}, c0, 16'b0}) +
                    $signed({{(SUM_W-PROD_W){p1[l][PROD_W-1]}}, p1[l]}) +
                    $signed({{(SUM_W-PROD_W){p2[l][PROD_W-1]}}, p2[l]});
      sc = $signed({sum[l], 8'b0}) - $signed({{8{sum[l][SUM_W-1]}}, sum[l]});
      cw_ch[l] = sat8($signed(sc[47:32]));
    end
  end

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      color.valid <= 1'b0;
    end else begin
      // a taken color clears valid unless a new one is loaded this cycle
      if (color.valid && color.ready && (state != ST_OUT)) begin
        color.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            unique case (q_kind)
              KIND_WHITE: begin
                for (int l = 0; l < LANES; l++) res[l] <= 8'd255;
                state <= ST_OUT;
              end
              KIND_ZERO: begin
                v     <= V_ZERO;
                state <= (map_sel == MAP_POLY) ? ST_SQ : ST_ANGLE;
              end
              KIND_ONE: begin
                v     <= V_ONE;
                state <= (map_sel == MAP_POLY) ? ST_SQ : ST_ANGLE;
              end
              KIND_DIV: begin
                rem   <= q_num;
                den_r <= q_den;
                quo   <= '0;
                cnt   <= '0;
                state <= ST_DIV;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            v     <= {1'b0, quo_next};
            state <= (map_sel == MAP_POLY) ? ST_SQ : ST_ANGLE;
          end
        end
        ST_SQ: begin
          v2    <= v_sq[2*V_BITS-1:QUO_BITS];
          state <= ST_POLY;
        end
        ST_POLY: begin
          for (int l = 0; l < LANES; l++) res[l] <= poly_ch[l];
          state <= ST_OUT;
        end
        ST_ANGLE: begin
          for (int l = 0; l < LANES; l++) cz[l] <= theta[l];
          state <= ST_REDUCE;
        end
        ST_REDUCE: begin
          // fold angles above pi/2 back by pi, negate results later
          for (int l = 0; l < LANES; l++) begin
            neg[l] <= (cz[l] > HALF_PI_Q16);
            if (cz[l] > HALF_PI_Q16) cz[l] <= cz[l] - PI_Q16;
            cx[l] <= CORDIC_GAIN;
            cy[l] <= '0;
          end
          cnt   <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          for (int l = 0; l < LANES; l++) begin
            cx[l] <= x_next[l];
            cy[l] <= y_next[l];
            cz[l] <= z_next[l];
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) state <= ST_PROD;
        end
        ST_PROD: begin
          for (int l = 0; l < LANES; l++) begin
            p1[l] <= p1_next[l];
            p2[l] <= p2_next[l];
          end
          state <= ST_SUM;
        end
        ST_SUM: begin
          for (int l = 0; l < LANES; l++) sum[l] <= sum_next[l];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          for (int l = 0; l < LANES; l++) res[l] <= cw_ch[l];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            color.valid <= 1'b1;
            color.red   <= res[0];
            color.green <= res[1];
            color.blue  <= res[2];
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb_false_color_value_mapper_top.sv
// ----------------------------------------------------------------------------
// tb_false_color_value_mapper_top
// Self-checking bench for the false-color mapper. Scan and map transactions
// are pushed through the sample channel in bursts. A built-in integer model
// of the range tracker, divider, polynomial map and CORDIC coolwarm map
// predicts every color, and a monitor compares each color transaction
// against the oldest prediction. The color sink stalls on its own pattern.
// The map select register is changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb_false_color_value_mapper_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcvm_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Color sink stall behaviors
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int PHASES         = 5;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam longint FRAC_ONE      = 65536;
  localparam longint ANGLE_HALF_PI = 102944;
  localparam longint ANGLE_PI      = 205887;
  localparam longint CORDIC_K      = 39797;
  localparam longint SAMPLE_MAX    = 64'sd2147483647;
  localparam longint SAMPLE_MIN    = -64'sd2147483648;

  // CORDIC arc tangents and per-channel coolwarm terms, all Q16
  longint cordic_atan [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
  longint cw_factor [3] = '{248250, 256508, 263717};
  longint cw_const  [3] = '{37775, 26142, 38876};
  longint cw_cos    [3] = '{-21706, -7366, 10610};
  longint cw_sin    [3] = '{13382, 28783, 24556};

  logic clk = 1'b0;
  logic rst = 1'b1;

  fcvm_in_if #(.SAMPLE_WIDTH(32)) item_if ();
  fcvm_out_if                     color_if ();
  fcvm_cfg_if                     cfg_if ();

  false_color_value_mapper_top #(.SAMPLE_WIDTH(32)) u_top (
    .clk   (clk),
    .rst   (rst),
    .item  (item_if),
    .color (color_if),
    .cfg   (cfg_if)
  );

  // Model state: selected map and tracked range
  map_t   active_map = MAP_POLY;
  longint range_lo   = SAMPLE_MAX;
  longint range_hi   = SAMPLE_MIN;
  rgb_t   color_q [$];
  rgb_t   exp_c;

  int error_count = 0;
  int n_sent      = 0;
  int n_scans     = 0;
  int n_maps_poly = 0;
  int n_maps_cool = 0;
  int n_white     = 0;
  int n_checked   = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int idle_cycles = 0;

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] clamp_u8(longint a);
    if (a < 0) return 8'd0;
    if (a > 255) return 8'd255;
    return a[7:0];
  endfunction

  function automatic logic signed [31:0] to_sample(longint a);
    if (a > SAMPLE_MAX) return 32'sh7FFFFFFF;
    if (a < SAMPLE_MIN) return 32'sh80000000;
    return a[31:0];
  endfunction

  // Expected color of a map transaction under the current range and map
  function automatic rgb_t compute_color(logic signed [31:0] smp);
    rgb_t            c;
    longint          den, num, v, v2, th, x, y, z, nx, acc;
    longint unsigned rem, d, q;
    bit              neg;
    logic [7:0]      lane_val [3];
    c = '{8'd255, 8'd255, 8'd255};
    if (smp < 0) return c;

    // normalize to Q0.16 by restoring division; empty or flat range gives 0
    v = 0;
    if (range_hi > range_lo) begin
      den = range_hi - range_lo;
      num = longint'(smp) - range_lo;
      if (num >= den) begin
        v = FRAC_ONE;
      end else if (num > 0) begin
        rem = num;
        d   = den;
        q   = 0;
        for (int i = 0; i < 16; i++) begin
          rem = rem << 1;
          q   = q << 1;
          if (rem >= d) begin
            rem = rem - d;
            q   = q | 64'd1;
          end
        end
        v = longint'(q);
      end
    end

    if (active_map == MAP_POLY) begin
      v2 = (v * v) >>> 16;
      c.red   = clamp_u8((255 * (2 * v - v2)) >>> 16);
      c.green = clamp_u8((255 * (4 * (v - v2))) >>> 16);
      c.blue  = clamp_u8((255 * (FRAC_ONE - v2)) >>> 16);
    end else begin
      for (int k = 0; k < 3; k++) begin
        th = (cw_factor[k] * v) >>> 16;
        // CORDIC rotation, angles past pi/2 folded back by pi
        x   = CORDIC_K;
        y   = 0;
        z   = th;
        neg = 1'b0;
        if (z > ANGLE_HALF_PI) begin
          z   = z - ANGLE_PI;
          neg = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - cordic_atan[i];
          end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + cordic_atan[i];
          end
          x = nx;
        end
        if (neg) begin
          x = -x;
          y = -y;
        end
        acc = cw_const[k] * FRAC_ONE + cw_cos[k] * x + cw_sin[k] * y;
        lane_val[k] = clamp_u8((255 * acc) >>> 32);
      end
      c.red   = lane_val[0];
      c.green = lane_val[1];
      c.blue  = lane_val[2];
    end
    return c;
  endfunction

  // Send one sample transaction; bursts with random gaps between them
  task automatic send_item(cmd_t cmd, logic signed [31:0] smp, logic fst);
    int     gap;
    longint x;
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_if.valid   <= 1'b1;
    item_if.command <= cmd;
    item_if.sample  <= smp;
    item_if.first   <= fst;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    n_sent++;
    if (cmd == CMD_SCAN) begin
      x = longint'(smp);
      if (fst) begin
        range_lo = x;
        range_hi = x;
      end else begin
        if (x < range_lo) range_lo = x;
        if (x > range_hi) range_hi = x;
      end
      n_scans++;
    end else begin
      if (smp < 0) n_white++;
      else if (active_map == MAP_POLY) n_maps_poly++;
      else n_maps_cool++;
      color_q.push_back(compute_color(smp));
    end
  endtask

  // Hold the sample channel idle until all colors are in, then settle
  task automatic wait_drained(int settle);
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_map_select(map_t m);
    wait_drained(SETTLE_CYCLES);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.map_select <= m;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    active_map = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Range edges, inside points, outside points, negative and largest sample
  task automatic run_sweep();
    send_item(CMD_SCAN, 32'sd1000000, 1'b1);
    send_item(CMD_SCAN, 32'sd0, 1'b0);
    send_item(CMD_SCAN, 32'sd300000, 1'b0);
    send_item(CMD_MAP, 32'sd0, 1'b0);
    send_item(CMD_MAP, 32'sd1000000, 1'b1);
    send_item(CMD_MAP, 32'sd999999, 1'b0);
    send_item(CMD_MAP, 32'sd1, 1'b0);
    send_item(CMD_MAP, 32'sd423000, 1'b0);
    send_item(CMD_MAP, 32'sd2000000, 1'b0);
    send_item(CMD_MAP, -32'sd1, 1'b0);
    send_item(CMD_MAP, 32'sh7FFFFFFF, 1'b0);
  endtask

  // Maps with no range yet, then a flat range built without the first flag
  task automatic test_reset_defaults();
    send_item(CMD_MAP, 32'sd0, 1'b0);
    send_item(CMD_MAP, 32'sh7FFFFFFF, 1'b1);
    send_item(CMD_MAP, 32'sh80000000, 1'b0);
    send_item(CMD_SCAN, 32'sd1000, 1'b0);
    send_item(CMD_MAP, 32'sd1000, 1'b0);
    send_item(CMD_MAP, 32'sd2000, 1'b0);
  endtask

  task automatic test_poly_map();
    write_map_select(MAP_POLY);
    run_sweep();
  endtask

  task automatic test_coolwarm_map();
    write_map_select(MAP_COOLWARM);
    run_sweep();
  endtask

  // One random sequence: a range scan followed by maps, or plain noise
  task automatic gen_segment();
    longint lo, hi, span, x;
    bit     hi_first;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(cmd_t'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      return;
    end

    // range base, mostly non-negative so maps reach the color engine
    case ($urandom_range(0, 4))
      0, 1, 2: lo = longint'($urandom_range(0, 1 << 20));
      3:       lo = longint'($urandom >> 1);
      default: lo = longint'($signed($urandom));
    endcase
    case ($urandom_range(0, 9))
      0:       span = 0;
      1, 2, 3: span = longint'($urandom_range(1, 16));
      4, 5, 6: span = longint'($urandom_range(17, 1 << 18));
      default: span = longint'($urandom >> 1);
    endcase
    hi = lo + span;
    if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
    span = hi - lo;

    // scans; occasionally the other edge is left out
    hi_first = 1'($urandom_range(0, 1));
    send_item(CMD_SCAN, to_sample(hi_first ? hi : lo), 1'b1);
    if ($urandom_range(0, 7) != 0)
      send_item(CMD_SCAN, to_sample(hi_first ? lo : hi), 1'b0);
    repeat ($urandom_range(0, 3))
      send_item(CMD_SCAN, to_sample(lo + longint'({$urandom, $urandom} % (span + 1))),
                1'b0);

    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: x = lo + longint'({$urandom, $urandom} % (span + 1));
        5:             x = lo;
        6:             x = hi;
        7:             x = lo - longint'($urandom_range(1, 64));
        8:             x = hi + longint'($urandom_range(1, 64));
        default:       x = longint'($signed($urandom));
      endcase
      send_item(CMD_MAP, to_sample(x), 1'($urandom_range(0, 1)));
    end
  endtask

  // Random phases, each under its own map select, with drain pauses
  task automatic test_random_phases();
    map_t sel;
    int   phase_end;
    bit   paused;
    for (int p = 0; p < PHASES; p++) begin
      sel = (p == PHASES - 1) ? map_t'($urandom_range(0, 1)) : map_t'(p % 2);
      write_map_select(sel);
      gaps_on   = (p % 2 == 0);
      phase_end = n_sent + RANDOM_ITEMS / PHASES;
      paused    = 1'b0;
      while (n_sent < phase_end) begin
        gen_segment();
        if ($urandom_range(0, 7) == 0) gaps_on = ~gaps_on;
        if (!paused || $urandom_range(0, 39) == 0) begin
          wait_drained(0);
          paused = 1'b1;
        end
      end
    end
  endtask

  // Color sink ready: picks a new random stall behavior whenever the current one runs out
  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_tick;
    color_if.ready = 1'b0;
    rx_mode = RX_ALWAYS;
    rx_left = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS: color_if.ready <= 1'b1;
        RX_COIN:   color_if.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: color_if.ready <= ($urandom_range(0, 3) == 0);
        default:   color_if.ready <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  // Color monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && color_if.valid === 1'b1 && color_if.ready === 1'b1) begin
      if (color_q.size() == 0) begin
        $error("unexpected color transaction: red %0d green %0d blue %0d",
               color_if.red, color_if.green, color_if.blue);
        error_count++;
      end else begin
        exp_c = color_q.pop_front();
        n_checked++;
        if (color_if.red !== exp_c.red) begin
          $error("red mismatch: expected %0d, actual %0d", exp_c.red, color_if.red);
          error_count++;
        end
        if (color_if.green !== exp_c.green) begin
          $error("green mismatch: expected %0d, actual %0d", exp_c.green, color_if.green);
          error_count++;
        end
        if (color_if.blue !== exp_c.blue) begin
          $error("blue mismatch: expected %0d, actual %0d", exp_c.blue, color_if.blue);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
        (color_if.valid === 1'b1 && color_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d colors outstanding",
                 idle_cycles, color_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    item_if.valid     = 1'b0;
    item_if.command   = CMD_SCAN;
    item_if.sample    = '0;
    item_if.first     = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.map_select = MAP_POLY;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_poly_map();
    test_coolwarm_map();
    test_random_phases();
    wait_drained(SETTLE_CYCLES);

    $display("Covered %0d scans and %0d maps (%0d polynomial, %0d coolwarm, %0d negative).",
             n_scans, n_maps_poly + n_maps_cool + n_white, n_maps_poly, n_maps_cool,
             n_white);
    $display("%0d colors checked, %0d errors.", n_checked, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
